/* hdl/mm_pkg.sv */
// Shared types and codes for the matrix multiplier.
`timescale 1ns / 1ps

package mm_pkg;

   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 36;
   localparam int POS_W  = 3;
   localparam int SIZE_W = 4;

   localparam logic [1:0] MODE_LOAD_A  = 2'd0;
   localparam logic [1:0] MODE_LOAD_B  = 2'd1;
   localparam logic [1:0] MODE_COMPUTE = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]               mode;
      logic [POS_W-1:0]         elem_row;
      logic [POS_W-1:0]         elem_col;
      logic signed [ELEM_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]        out_row;
      logic [POS_W-1:0]        out_col;
      logic signed [SUM_W-1:0] product_value;
      logic                    last;
   } rsp_type;

   // Control that travels down the multiply-accumulate pipeline with each term.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } ctl_type;

endpackage

/* hdl/mm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mm_mac.sv */
// Shared multiply-accumulate unit: registered product, then accumulate and emit.
`timescale 1ns / 1ps

module mm_mac
   import mm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  ctl,
   input  logic signed [ELEM_W-1:0] a_value,
   input  logic signed [ELEM_W-1:0] b_value,
   output logic                     rsp_valid,
   output rsp_type                  rsp_item
);

   logic signed [PROD_W-1:0] prod_ff;
   ctl_type                  ctl_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  prod_ext;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   assign prod_ext = {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_in   = ctl_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl.valid;
         rsp_valid_ff <= ctl_ff.valid && ctl_ff.last_k;
      end
      prod_ff       <= a_value * b_value;
      ctl_ff.first  <= ctl.first;
      ctl_ff.last_k <= ctl.last_k;
      ctl_ff.row    <= ctl.row;
      ctl_ff.col    <= ctl.col;
      ctl_ff.last   <= ctl.last;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
      rsp_ff.out_row       <= ctl_ff.row;
      rsp_ff.out_col       <= ctl_ff.col;
      rsp_ff.product_value <= acc_in;
      rsp_ff.last          <= ctl_ff.last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hdl/matrix_multiply.sv */
// Top level of the square matrix multiplier: load sequencer, RAMs and MAC.
`timescale 1ns / 1ps

// Square matrix multiply C = A x B for sizes up to MAX_N. A beat on the
// request side is taken when start is high and busy is low. A load beat
// (mode load A or load B) writes one Q1.15 element and does not raise busy, so
// loads stream at one per clock; a load outside MAX_N is dropped, as is a
// beat with the unused mode. A compute beat walks all n*n*n terms through
// one shared 16x16 multiplier and 36-bit accumulator, one term per clock,
// with A and B each in a RAM read once per clock. Results leave in
// row-major order, one beat per element, each on rsp_valid for exactly one
// cycle with last on the final one; the receiver cannot stall, so take
// every strobe. Busy stays high from the compute beat until the final
// element has left the multiply pipeline (RAM read, product, accumulate);
// the next beat is taken once busy is low. The matrix_size register is
// written through the csr_ channel while the block is idle; 0 acts as 1 and a
// value above MAX_N acts as MAX_N. Entries of A and B have no reset value:
// read only what you have loaded.
module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DEPTH  = MAX_N * MAX_N;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  nm1_ff, nm1_in;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_eff;
   ctl_type           ctl_rd_ff;
   ctl_type           ctl_issue;

   logic              accept;
   logic              load_ok;
   logic              we_a, we_b;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0] a_rd_data, b_rd_data;
   logic              i_end, j_end, k_end;

   // Configuration register: take a write only while idle.
   assign csr_ready = ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   // Clamp the size in use to 1 .. MAX_N.
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_N)) begin
         size_eff = SIZE_W'(MAX_N);
      end else begin
         size_eff = size_ff;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Loads: drop any beat whose row or column falls outside the array.
   assign load_ok = ({1'b0, req_item.elem_row} < SIZE_W'(MAX_N)) &&
                    ({1'b0, req_item.elem_col} < SIZE_W'(MAX_N));
   assign we_a    = accept && load_ok && (req_item.mode == MODE_LOAD_A);
   assign we_b    = accept && load_ok && (req_item.mode == MODE_LOAD_B);
   assign wr_addr = ADDR_W'(ADDR_W'(IDX_W'(req_item.elem_row)) * ADDR_W'(MAX_N)
                    + ADDR_W'(IDX_W'(req_item.elem_col)));

   // Term addresses: A[i][k] and B[k][j].
   assign a_rd_addr = ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(MAX_N) + ADDR_W'(k_ff));
   assign b_rd_addr = ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(MAX_N) + ADDR_W'(j_ff));

   mm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (req_item.elem_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (req_item.elem_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign i_end = (i_ff == nm1_ff);
   assign j_end = (j_ff == nm1_ff);
   assign k_end = (k_ff == nm1_ff);

   // Control for the term issued this cycle; it meets the RAM data next cycle.
   always_comb begin
      ctl_issue.valid  = (state_ff == ST_ISSUE);
      ctl_issue.first  = (k_ff == '0);
      ctl_issue.last_k = k_end;
      ctl_issue.row    = POS_W'(i_ff);
      ctl_issue.col    = POS_W'(j_ff);
      ctl_issue.last   = i_end && j_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_rd_ff.valid <= 1'b0;
      end else begin
         ctl_rd_ff.valid <= ctl_issue.valid;
      end
      ctl_rd_ff.first  <= ctl_issue.first;
      ctl_rd_ff.last_k <= ctl_issue.last_k;
      ctl_rd_ff.row    <= ctl_issue.row;
      ctl_rd_ff.col    <= ctl_issue.col;
      ctl_rd_ff.last   <= ctl_issue.last;
   end

   mm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_rd_ff),
      .a_value   (a_rd_data),
      .b_value   (b_rd_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Sequencer: walk k fastest, then j, then i; drain the pipe after the
   // last term and drop busy once the final element has gone out.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      nm1_in   = nm1_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.mode == MODE_COMPUTE)) begin
               state_in = ST_ISSUE;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               nm1_in   = IDX_W'(size_eff - SIZE_W'(1));
            end
         end
         ST_ISSUE: begin
            if (!k_end) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!j_end) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_item.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      nm1_ff <= nm1_in;
   end

   // A result beat only appears while a compute run is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // The final element of a run releases the block on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |=> !busy)
      else $error("busy held after final element");

   // A compute beat always starts a run.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode == MODE_COMPUTE)) |=> busy)
      else $error("compute beat did not start a run");

   // Results leave in row-major order: a non-final beat is never flagged last
   // unless it is at the corner of the active size.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |->
         (rsp_item.out_row == POS_W'(nm1_ff)) && (rsp_item.out_col == POS_W'(nm1_ff)))
      else $error("last flag on wrong element");

endmodule

/* tb/sv/matrix_multiply_test.sv */
// Self-checking bench for the matrix multiplier: element loads, products and size register.
`timescale 1ns / 1ps

module matrix_multiply_test
   import mm_pkg::*;
;

   localparam int         MAX_N         = 8;
   localparam int         CELLS         = MAX_N * MAX_N;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam shortint    ELEM_MAX      = 32767;
   localparam shortint    ELEM_MIN      = -32768;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         REPORT_LIMIT  = 10;
   localparam int         PHASE_ITEMS   = 127;

   // Mirror of both operand stores and the size register; expands each compute
   // beat into the full row-major list of product elements it must produce.
   class product_tracker;
      shortint           a_store[CELLS];
      shortint           b_store[CELLS];
      logic [SIZE_W-1:0] size_reg = SIZE_RESET;
      rsp_type           pending_elems[$];
      int                mismatches = 0;

      function void set_size(logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      // Zero behaves as one, anything past MAX_N as MAX_N.
      function int active_size();
         if (size_reg == 0) return 1;
         if (size_reg > MAX_N) return MAX_N;
         return int'(size_reg);
      endfunction

      function int pending();
         return pending_elems.size();
      endfunction

      function void take_request(req_type item);
         int      n;
         longint  acc;
         rsp_type elem;
         case (item.mode)
            MODE_LOAD_A: a_store[{item.elem_row, item.elem_col}] = item.elem_value;
            MODE_LOAD_B: b_store[{item.elem_row, item.elem_col}] = item.elem_value;
            MODE_COMPUTE: begin
               n = active_size();
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++) begin
                     // Exact sum of Q1.15 products, accumulated in order of k.
                     acc = 0;
                     for (int k = 0; k < n; k++)
                        acc += longint'(a_store[i*MAX_N+k]) * longint'(b_store[k*MAX_N+j]);
                     elem.out_row       = i[POS_W-1:0];
                     elem.out_col       = j[POS_W-1:0];
                     elem.product_value = acc[SUM_W-1:0];
                     elem.last          = (i == n - 1) && (j == n - 1);
                     pending_elems.push_back(elem);
                  end
               end
            end
            default: ;  // unused mode: no effect
         endcase
      endfunction

      function void check_element(rsp_type got);
         rsp_type want;
         if (pending_elems.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected product element (%0d,%0d) value %0d last %0d",
                        got.out_row, got.out_col, got.product_value, got.last);
            mismatches++;
            return;
         end
         want = pending_elems.pop_front();
         if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
             got.product_value !== want.product_value || got.last !== want.last) begin
            if (mismatches < REPORT_LIMIT)
               $display({"product mismatch: expected (%0d,%0d) %0d last %0d,",
                         " got (%0d,%0d) %0d last %0d"},
                        want.out_row, want.out_col, want.product_value, want.last,
                        got.out_row, got.out_col, got.product_value, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_item;
   logic              rsp_valid;
   rsp_type           rsp_item;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data;

   product_tracker board;
   bit             a_loaded[CELLS];
   bit             b_loaded[CELLS];
   int             items_sent;
   int             idle_pct;
   int             quiet_cycles = 0;

   matrix_multiply #(
      .MAX_N(MAX_N)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly random, with the full-scale corners and small values weighted up.
   function automatic shortint pick_value();
      case ($urandom_range(7))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2:       return shortint'(0);
         3:       return shortint'(-1);
         default: return shortint'($urandom);
      endcase
   endfunction

   // Present one request beat and hold it until the block takes it. Start stays
   // high on return so back-to-back beats need no extra assignment; busy is
   // sampled at the falling edge, where it is stable for the next rising edge.
   task automatic send_item(input req_type item);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      board.take_request(item);
      if (item.mode != MODE_UNUSED) items_sent++;
   endtask

   task automatic send_load(input logic [1:0] mode, input int row, input int col,
                            input shortint value);
      req_type item;
      item.mode       = mode;
      item.elem_row   = row[POS_W-1:0];
      item.elem_col   = col[POS_W-1:0];
      item.elem_value = value;
      if (mode == MODE_LOAD_A) a_loaded[row*MAX_N+col] = 1'b1;
      else                     b_loaded[row*MAX_N+col] = 1'b1;
      send_item(item);
   endtask

   // Load whatever the active size would read but was never written, then
   // issue the compute beat; its index and value bits are don't-care.
   task automatic run_product();
      int      n;
      req_type item;
      n = board.active_size();
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!a_loaded[r*MAX_N+c]) send_load(MODE_LOAD_A, r, c, pick_value());
            if (!b_loaded[r*MAX_N+c]) send_load(MODE_LOAD_B, r, c, pick_value());
         end
      end
      item.mode       = MODE_COMPUTE;
      item.elem_row   = POS_W'($urandom_range(7));
      item.elem_col   = POS_W'($urandom_range(7));
      item.elem_value = shortint'($urandom);
      send_item(item);
   endtask

   // Drop start and wait until every predicted element is back and busy is low.
   task automatic wait_idle();
      bit quiet;
      start <= 1'b0;
      do begin
         @(negedge clock);
         quiet = !busy;
         @(posedge clock);
      end while (!quiet || board.pending() != 0);
   endtask

   // Size changes only go in while the block is idle.
   task automatic write_size(input logic [SIZE_W-1:0] value);
      bit taken;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      board.set_size(value);
   endtask

   // Check every result strobe and watch for a stalled run.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_element(rsp_item);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int                n;
      int                roll;
      int                goal;
      int                burst;
      shortint           a_ext;
      shortint           b_ext;
      logic [SIZE_W-1:0] raw;
      req_type           item;

      board      = new();
      items_sent = 0;
      idle_pct   = 36;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale operands of both signs at a small size.
      write_size(4'd2);
      send_load(MODE_LOAD_A, 0, 0, ELEM_MAX);
      send_load(MODE_LOAD_A, 0, 1, ELEM_MIN);
      send_load(MODE_LOAD_A, 1, 0, 0);
      send_load(MODE_LOAD_A, 1, 1, 1);
      send_load(MODE_LOAD_B, 0, 0, ELEM_MIN);
      send_load(MODE_LOAD_B, 0, 1, ELEM_MAX);
      send_load(MODE_LOAD_B, 1, 0, ELEM_MIN);
      send_load(MODE_LOAD_B, 1, 1, -1);
      run_product();

      // Every term is (-1) x (-1): the largest positive sum at this size.
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 2; c++) begin
            send_load(MODE_LOAD_A, r, c, ELEM_MIN);
            send_load(MODE_LOAD_B, r, c, ELEM_MIN);
         end
      end
      run_product();

      // Unused mode with every other bit set must leave both stores alone.
      item            = '1;
      item.mode       = MODE_UNUSED;
      send_item(item);
      // A corner load outside the active size must not disturb the product.
      send_load(MODE_LOAD_A, MAX_N - 1, MAX_N - 1, ELEM_MAX);
      send_load(MODE_LOAD_B, MAX_N - 1, MAX_N - 1, ELEM_MIN);
      run_product();

      // Size zero behaves as one.
      write_size(4'd0);
      run_product();

      // Random: sender gaps at 36 %, then 50 %, then back-to-back beats.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
         write_size((phase == 0) ? 4'd3 : (phase == 1) ? 4'd15 : 4'd8);
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(99) < 25) begin
               // Keep most sizes small; the big ones run n cubed terms each.
               roll = $urandom_range(99);
               if (roll < 8)       raw = '0;
               else if (roll < 58) raw = SIZE_W'($urandom_range(3, 1));
               else if (roll < 80) raw = SIZE_W'($urandom_range(5, 4));
               else if (roll < 90) raw = SIZE_W'($urandom_range(7, 6));
               else if (roll < 95) raw = SIZE_W'(MAX_N);
               else                raw = SIZE_W'($urandom_range(15, 9));
               write_size(raw);
            end
            roll = $urandom_range(99);
            n    = board.active_size();
            if (roll < 65) begin
               // Refresh a random part of both operands, then multiply.
               for (int r = 0; r < n; r++) begin
                  for (int c = 0; c < n; c++) begin
                     if (!a_loaded[r*MAX_N+c] || $urandom_range(1))
                        send_load(MODE_LOAD_A, r, c, pick_value());
                     if (!b_loaded[r*MAX_N+c] || $urandom_range(1))
                        send_load(MODE_LOAD_B, r, c, pick_value());
                  end
               end
               run_product();
            end else if (roll < 78) begin
               // Fill each operand with one full-scale value: widest sums.
               a_ext = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
               b_ext = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
               for (int r = 0; r < n; r++) begin
                  for (int c = 0; c < n; c++) begin
                     send_load(MODE_LOAD_A, r, c, a_ext);
                     send_load(MODE_LOAD_B, r, c, b_ext);
                  end
               end
               run_product();
            end else begin
               // Noise: stray loads anywhere, unused modes, early computes.
               burst = $urandom_range(4, 1);
               repeat (burst) begin
                  item.mode       = 2'($urandom_range(3));
                  item.elem_row   = POS_W'($urandom_range(7));
                  item.elem_col   = POS_W'($urandom_range(7));
                  item.elem_value = shortint'($urandom);
                  if (item.mode == MODE_COMPUTE)
                     run_product();
                  else if (item.mode == MODE_UNUSED)
                     send_item(item);
                  else
                     send_load(item.mode, item.elem_row, item.elem_col, item.elem_value);
               end
            end
         end
      end

      // Drain: every element back, then let the pipeline run dry.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
